@@ hdl/fms_pkg.sv @@
package fms_pkg;
    localparam int unsigned MaxNDefault = 1024;
    localparam int unsigned ModW = 16;
    localparam int unsigned NW = 10;
    localparam logic [ModW-1:0] ModulusReset = 16'd1;
    localparam logic [0:0] AddrModulus = 1'b0;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_mul_ctl;
endpackage

@@ hdl/fms_modmul.sv @@
module fms_modmul
    import fms_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [ModW-1:0] i_a,
    input  logic [ModW-1:0] i_b,
    input  logic [ModW-1:0] i_m,
    output t_mul_ctl        o_ctl,
    output logic [ModW-1:0] o_prod
);
    // Bit-serial interleaved modular multiply: one bit of b per cycle, MSB first.
    localparam int unsigned CW = $clog2(ModW + 1);
    logic [ModW-1:0] r_acc, r_a, r_b, r_m;
    logic [CW-1:0]   r_cnt;
    logic            r_busy, r_done;
    logic [ModW+1:0] w_dbl, w_d1, w_add, w_a1;

    always_comb begin
        w_dbl = {2'b00, r_acc} << 1;
        w_d1  = (w_dbl >= {2'b00, r_m}) ? w_dbl - {2'b00, r_m} : w_dbl;
        w_add = w_d1 + (r_b[ModW-1] ? {2'b00, r_a} : '0);
        w_a1  = (w_add >= {2'b00, r_m}) ? w_add - {2'b00, r_m} : w_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ModW);
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_m    <= i_m;
            end else if (r_busy) begin
                r_acc <= w_a1[ModW-1:0];
                r_b   <= r_b << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_ctl  = '{start: i_start, busy: r_busy, done: r_done};
    assign o_prod = r_acc;
endmodule

@@ hdl/factorial_mod_sieve_core.sv @@
// Per item: the bitmap for 0..n is filled (rewritten, not cleared), sieved up to sqrt(n),
// then scanned; per prime, restoring divisions give Legendre's exponent and modular
// multiplies raise the prime to it and fold it into the result.
// Throughput: one transaction at a time; o_ready returns the cycle after the result leaves.
// When n >= modulus or n >= MAX_N, o_valid is set at the accepting edge with residue 0.
// Reset is synchronous, active low, and sets the modulus to 1.
module factorial_mod_sieve_core
    import fms_pkg::*;
#(
    parameter int unsigned MAX_N = MaxNDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [NW-1:0]   i_n_value,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [ModW-1:0] o_residue,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [1:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    localparam int unsigned AW = $clog2(MAX_N);
    localparam int unsigned IW = AW + 1;
    localparam int unsigned KW = 16;

    typedef enum logic [3:0] {
        S_IDLE, S_FILL, S_SI_RD, S_SI_CHK, S_SI_CLR, S_SC_RD, S_SC_CHK,
        S_LEG, S_POW, S_PMUL, S_PSQ, S_AMUL, S_OUT
    } t_state;

    t_state          r_state;
    logic [ModW-1:0] r_mod, r_m, r_acc, r_pacc, r_base, r_res;
    logic [IW-1:0]   r_n, r_i, r_j;
    logic [KW-1:0]   r_k, r_quot, r_rem, r_div;
    logic [4:0]      r_dcnt;
    logic            r_valid, r_rd;
    logic            r_mem [MAX_N];
    logic [AW-1:0]   w_waddr, w_raddr;
    logic            w_we, w_wd;

    logic            w_start;
    logic [ModW-1:0] w_a, w_b, w_prod;
    t_mul_ctl        w_ctl;

    fms_modmul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_a(w_a), .i_b(w_b), .i_m(r_m), .o_ctl(w_ctl), .o_prod(w_prod)
    );

    assign pready = 1'b1;
    assign prdata = {16'd0, r_mod};
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_residue = r_res;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wd;
        r_rd <= r_mem[w_raddr];
    end

    // Restoring division n/q, one quotient bit per cycle, for Legendre's sum.
    logic [KW-1:0] w_rs;
    assign w_rs = {r_rem[KW-2:0], r_quot[KW-1]};

    always_comb begin
        w_we = 1'b0;
        w_wd = 1'b0;
        w_waddr = r_j[AW-1:0];
        w_raddr = r_i[AW-1:0];
        case (r_state)
            S_FILL:   begin w_we = 1'b1; w_wd = 1'b1; w_waddr = r_i[AW-1:0]; end
            S_SI_CLR: begin w_we = 1'b1; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_mod   <= ModulusReset;
        end else begin
            if (psel && penable && pwrite && paddr[1:1] == AddrModulus)
                r_mod <= pwdata[ModW-1:0];
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_n <= IW'(i_n_value);
                    r_m <= r_mod;
                    r_acc <= (r_mod == 16'd1) ? '0 : 16'd1;
                    r_i <= '0;
                    if ({6'd0, i_n_value} >= r_mod
                        || 32'(i_n_value) >= 32'(MAX_N)) begin
                        r_res <= '0;
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                    end else r_state <= S_FILL;
                end
                S_FILL: begin
                    if (r_i == r_n) begin
                        r_i <= IW'(2);
                        r_state <= S_SI_RD;
                    end else r_i <= r_i + 1'b1;
                end
                S_SI_RD: begin
                    if (32'(r_i) * 32'(r_i) > 32'(r_n)) begin
                        r_i <= IW'(2);
                        r_state <= S_SC_RD;
                    end else r_state <= S_SI_CHK;
                end
                S_SI_CHK: begin
                    if (r_rd) begin
                        r_j <= r_i + r_i;
                        r_state <= S_SI_CLR;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_SI_RD;
                    end
                end
                S_SI_CLR: begin
                    if (r_j + r_i > r_n) begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_SI_RD;
                    end else r_j <= r_j + r_i;
                end
                S_SC_RD: begin
                    if (r_i > r_n || r_m < 16'd2) begin
                        r_res <= r_acc;
                        r_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else r_state <= S_SC_CHK;
                end
                S_SC_CHK: begin
                    if (r_rd) begin
                        r_k <= '0;
                        r_quot <= KW'(r_n);
                        r_rem <= '0;
                        r_div <= KW'(r_i);
                        r_dcnt <= 5'd16;
                        r_state <= S_LEG;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_SC_RD;
                    end
                end
                S_LEG: begin
                    if (r_dcnt != 5'd0) begin
                        if (w_rs >= r_div) begin
                            r_rem <= w_rs - r_div;
                            r_quot <= {r_quot[KW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rs;
                            r_quot <= {r_quot[KW-2:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt - 1'b1;
                    end else if (r_quot == '0) begin
                        r_pacc <= 16'd1;
                        r_base <= (KW'(r_i) >= r_m) ? KW'(r_i) - r_m : KW'(r_i);
                        r_state <= S_POW;
                    end else begin
                        r_k <= r_k + r_quot;
                        r_rem <= '0;
                        r_dcnt <= 5'd16;
                    end
                end
                S_POW: begin
                    if (r_k == '0) r_state <= S_AMUL;
                    else if (r_k[0]) r_state <= S_PMUL;
                    else r_state <= S_PSQ;
                end
                S_PMUL: if (w_ctl.done) begin
                    r_pacc <= w_prod;
                    r_state <= S_PSQ;
                end
                S_PSQ: if (w_ctl.done) begin
                    r_base <= w_prod;
                    r_k <= r_k >> 1;
                    r_state <= S_POW;
                end
                S_AMUL: if (w_ctl.done) begin
                    r_acc <= w_prod;
                    r_i <= r_i + 1'b1;
                    r_state <= S_SC_RD;
                end
                S_OUT: if (i_ready) begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Multiplier launch: pulse once on entry to each multiply state.
    logic r_launched;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_launched <= 1'b0;
        else if (w_ctl.done) r_launched <= 1'b0;
        else if (w_start) r_launched <= 1'b1;
    end
    always_comb begin
        w_a = r_pacc;
        w_b = r_base;
        case (r_state)
            S_PSQ:  begin w_a = r_base; w_b = r_base; end
            S_AMUL: begin w_a = r_acc;  w_b = r_pacc; end
            default: ;
        endcase
    end
    assign w_start = (r_state == S_PMUL || r_state == S_PSQ || r_state == S_AMUL)
                     && !r_launched && !w_ctl.busy && !w_ctl.done;
endmodule

@@ hdl/fms_checker.sv @@
module fms_checker
    import fms_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_ready,
    input logic            o_valid,
    input logic            i_ready,
    input logic [ModW-1:0] o_residue
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_residue)) else $error("held");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("overlap");
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid) else $error("dup");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("busy");
endmodule

bind factorial_mod_sieve_core fms_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_residue(o_residue)
);
